// ===== design/chd_pkg.sv =====
`timescale 1ns / 1ps

package chd_pkg;

    localparam int NUM_CORES = 4;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_ENABLE      = 3'd0;
    localparam logic [2:0] CFG_START_DELAY = 3'd1;
    localparam logic [2:0] CFG_MAX_CORES   = 3'd2;
    localparam logic [2:0] CFG_MIN_CORES   = 3'd3;
    localparam logic [2:0] CFG_DEPTH_TABLE = 3'd4;
    localparam logic [2:0] CFG_TIME_TABLE  = 3'd5;

    localparam logic [15:0] START_DELAY_RST = 16'd20000;
    localparam logic [2:0]  MAX_CORES_RST   = 3'd4;
    localparam logic [2:0]  MIN_CORES_RST   = 3'd1;
    // Entry i in bits 8i+7..8i: up/down pairs for 1..4 online cores
    localparam logic [63:0] DEPTH_TABLE_RST = 64'h1400_121E_1018_0E12;
    localparam logic [63:0] TIME_TABLE_RST  = 64'h6400_6446_6446_0046;

    typedef enum logic [1:0] {
        ACT_HOLD     = 2'd0,
        ACT_ADD      = 2'd1,
        ACT_REMOVE   = 2'd2,
        ACT_DISABLED = 2'd3
    } t_action;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] queue_depth;
        logic [3:0]  online_mask;
        logic [15:0] load_core1;
        logic [15:0] load_core2;
        logic [15:0] load_core3;
    } t_in_item;

    typedef struct packed {
        t_action     action;
        logic [1:0]  remove_core;
    } t_out_item;

endpackage

// ===== design/core_hotplug_decision.sv =====
`timescale 1ns / 1ps

// Core hotplug decision block.
// One input transaction per sample tick carries the timestamp, run-queue depth,
// online-core mask and the loads of cores 1 to 3. Each tick yields exactly one
// output transaction: hold, add a core, remove a core (with the core to drop),
// or disabled.
// Both channels are valid/ready. The decision is computed in the cycle the
// input transaction is accepted and lands in the output register, or in the
// skid register. A new tick can be taken every cycle while input ready is high:
// the accumulator update is a subtract, a saturating add and byte compares. A
// skid register behind the output register keeps input ready high while one
// result waits; input ready drops only when two results are pending, i.e. once
// the receiver stalls while a result waits and another tick is accepted. Ready
// returns the cycle after the receiver takes a result. Configuration writes
// (enable, start delay, core limits, threshold tables) take effect at the next
// tick and must be made by the user while no tick is in flight (unenforced).
// Reset restores the register defaults, clears the time accumulator, marks the
// next processed tick as the first one and empties the output side.
module core_hotplug_decision (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  chd_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output chd_pkg::t_out_item o_out_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data
);
    import chd_pkg::*;

    logic        r_enable;
    logic [15:0] r_start_delay;
    logic [2:0]  r_max_cores;
    logic [2:0]  r_min_cores;
    logic [63:0] r_depth_table;
    logic [63:0] r_time_table;

    logic [31:0] r_accum, n_accum;
    logic [31:0] r_prev_time;
    logic        r_first, n_first;
    logic        r_out_valid, r_skid_valid;
    t_out_item   r_out, r_skid, n_result;

    logic        in_acc, out_take;
    logic [2:0]  num_online;
    logic [2:0]  up_idx, dn_idx;
    logic [7:0]  up_depth, dn_depth, up_time, dn_time;
    logic [32:0] sum;
    logic [31:0] delta, acc_cur;
    logic        up_branch;
    logic [16:0] best;
    logic [15:0] loads [1:3];

    assign in_acc      = i_in_valid && o_in_ready;
    assign out_take    = r_out_valid && i_out_ready;
    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b1;
            r_start_delay <= START_DELAY_RST;
            r_max_cores   <= MAX_CORES_RST;
            r_min_cores   <= MIN_CORES_RST;
            r_depth_table <= DEPTH_TABLE_RST;
            r_time_table  <= TIME_TABLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE:      r_enable      <= i_cfg_data[0];
                CFG_START_DELAY: r_start_delay <= i_cfg_data[15:0];
                CFG_MAX_CORES:   r_max_cores   <= i_cfg_data[2:0];
                CFG_MIN_CORES:   r_min_cores   <= i_cfg_data[2:0];
                CFG_DEPTH_TABLE: r_depth_table <= i_cfg_data;
                CFG_TIME_TABLE:  r_time_table  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        num_online = 3'(i_in_data.online_mask[0]) + 3'(i_in_data.online_mask[1])
                   + 3'(i_in_data.online_mask[2]) + 3'(i_in_data.online_mask[3]);
        up_idx   = {num_online[1:0] - 2'd1, 1'b0};
        dn_idx   = {num_online[1:0] - 2'd1, 1'b1};
        up_depth = r_depth_table[up_idx*8 +: 8];
        dn_depth = r_depth_table[dn_idx*8 +: 8];
        up_time  = r_time_table[up_idx*8 +: 8];
        dn_time  = r_time_table[dn_idx*8 +: 8];

        // Saturating accumulate of the tick-to-tick time
        delta   = i_in_data.now_ms - r_prev_time;
        sum     = {1'b0, r_accum} + {1'b0, delta};
        acc_cur = r_first ? r_accum : (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);

        loads[1] = i_in_data.load_core1;
        loads[2] = i_in_data.load_core2;
        loads[3] = i_in_data.load_core3;

        up_branch = (num_online < 3'(NUM_CORES))
                 && (i_in_data.queue_depth >= {8'd0, up_depth});

        n_accum  = r_accum;
        n_first  = r_first;
        n_result = '{action: ACT_HOLD, remove_core: 2'd0};
        best     = '1;

        if (!r_enable) begin
            n_result.action = ACT_DISABLED;
        end else if (i_in_data.now_ms > {16'd0, r_start_delay}) begin
            n_first = 1'b0;
            n_accum = acc_cur;
            if (num_online == 3'd0) begin
                n_accum = '0;
            end else if (up_branch) begin
                if (acc_cur >= {24'd0, up_time} && num_online < r_max_cores) begin
                    n_result.action = ACT_ADD;
                    n_accum = '0;
                end
            end else if (i_in_data.queue_depth <= {8'd0, dn_depth}) begin
                if (acc_cur >= {24'd0, dn_time} && num_online > 3'd1
                        && num_online > r_min_cores) begin
                    n_result.action = ACT_REMOVE;
                    n_accum = '0;
                end
            end else begin
                n_accum = '0;
            end
            if (n_result.action == ACT_REMOVE) begin
                // Least-loaded online core other than core 0; first lowest wins
                for (int i = 1; i < NUM_CORES; i++) begin
                    if (i_in_data.online_mask[i] && {1'b0, loads[i]} < best) begin
                        best = {1'b0, loads[i]};
                        n_result.remove_core = 2'(i);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_first <= 1'b1;
        end else if (in_acc) begin
            r_accum <= n_accum;
            r_first <= n_first;
        end
    end

    // Written on every processed tick; read only once written
    always_ff @(posedge i_clk) begin
        if (in_acc && r_enable && i_in_data.now_ms > {16'd0, r_start_delay}) begin
            r_prev_time <= i_in_data.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= in_acc;
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_take) begin
            if (in_acc) begin
                r_out <= n_result;
            end
        end else if (in_acc) begin
            r_skid <= n_result;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a transaction while output is empty");

    a_remove_names_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.action == ACT_REMOVE) |-> o_out_data.remove_core != 2'd0)
        else $error("remove decision names core 0");

    a_no_victim_otherwise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.action != ACT_REMOVE) |-> o_out_data.remove_core == 2'd0)
        else $error("core named without remove decision");

    a_decision_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (n_result.action == ACT_ADD || n_result.action == ACT_REMOVE))
        |=> r_accum == 32'd0)
        else $error("accumulator kept after decision");

    a_disabled_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_enable) |=> ($stable(r_accum) && $stable(r_first)))
        else $error("state changed while disabled");

endmodule
